// ===== rtl/core/skpq_pkg.sv =====
// ----------------------------------------------------------------------------
// skpq_pkg: shared types and constants of the speed keyed priority queue
// Field widths, queue depth, opcode and status codes, controller states and
// the slot record that moves along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package skpq_pkg;

    // Queue depth and key numerator
    localparam int CAPACITY      = 16;
    localparam int KEY_NUMERATOR = 1000;

    // Field widths
    localparam int OPC_W    = 2;
    localparam int ID_W     = 10;
    localparam int SPEED_W  = 8;
    localparam int WEIGHT_W = 16;
    localparam int KEY_W    = 17;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Divider widths: quotient bits and iteration counter
    localparam int QUO_W  = $clog2(KEY_NUMERATOR + 1);
    localparam int STEP_W = $clog2(QUO_W + 1);

    // Request opcodes
    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_slot;

    // Broadcast command to every cell
    typedef struct packed {
        logic  ins;
        logic  pop;
        t_slot slot;
    } t_cell_ctl;

endpackage : skpq_pkg

`default_nettype wire

// ===== rtl/core/speed_keyed_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// speed_keyed_priority_queue_core: bounded sorted queue of entity ids
// Requests arrive on i_valid/o_stall with an opcode (insert, pop, peek) and
// the insert payload. Each request yields one result on o_valid/i_stall with
// a status, the front or inserted entry and the occupancy afterwards.
// An insert keys the entry as KEY_NUMERATOR / speed + weight; the quotient
// comes from an iterative divider, one bit a cycle (QUO_W = 10 quotient bits).
// The entry is placed behind every entry with an equal or smaller key by one
// shift of the cell chain, so equal keys leave in arrival order.
// An insert passes through the divider (state S_DIV) before the chain update
// in S_DONE; pop and peek go straight to S_DONE.
// One request is in work at a time; o_stall is high from acceptance until
// the result is loaded, and only then is a new request taken.
// A full queue flags an insert, an empty queue flags pop and peek; the
// stored entries do not change in either case.
// Reset empties the queue at once and drops any pending result.
// While the receiver stalls, the result register holds and the next request
// is still accepted and worked; it finishes once the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_keyed_priority_queue_core
    import skpq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OPC_W-1:0]    i_opcode,
    input  wire logic [ID_W-1:0]     i_entity_id,
    input  wire logic [SPEED_W-1:0]  i_speed,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic [ID_W-1:0]          o_front_id,
    output logic [KEY_W-1:0]         o_front_key,
    output logic [CNT_W-1:0]         o_occupancy
);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [OPC_W-1:0]     r_op;
    logic [ID_W-1:0]      r_id;
    logic [WEIGHT_W-1:0]  r_weight;

    logic                 r_o_valid;
    logic [STAT_W-1:0]    r_o_status;
    logic [ID_W-1:0]      r_o_id;
    logic [KEY_W-1:0]     r_o_key;
    logic [CNT_W-1:0]     r_o_occ;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_apply;
    logic                 w_div_start;
    logic                 w_div_busy;
    logic [QUO_W-1:0]     w_quo;
    logic [KEY_W-1:0]     w_key;
    logic                 w_full;
    logic                 w_empty;
    t_cell_ctl            w_ctl;
    logic [STAT_W-1:0]    w_status;
    t_slot                w_res;

    t_slot                w_slot [CAPACITY];
    logic                 w_keep [CAPACITY];
    logic                 w_occ  [CAPACITY];

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_key      = KEY_W'(w_quo) + KEY_W'(r_weight);

    // Key divider
    skpq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_speed (i_speed),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_opcode) == OP_INSERT) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (!w_div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        o_stall     = 1'b1;
        w_div_start = 1'b0;
        w_apply     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall     = 1'b0;
                w_div_start = i_valid && (t_op'(i_opcode) == OP_INSERT);
            end
            S_DIV: begin
                o_stall = 1'b1;
            end
            S_DONE: begin
                w_apply = w_out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // Decode the request into a chain command and a result
    always_comb begin
        w_ctl.ins      = 1'b0;
        w_ctl.pop      = 1'b0;
        w_ctl.slot.id  = r_id;
        w_ctl.slot.key = w_key;
        n_count        = r_count;
        w_status       = STAT_OK;
        w_res          = w_slot[0];
        case (t_op'(r_op))
            OP_INSERT: begin
                w_res.id  = r_id;
                w_res.key = w_key;
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctl.ins = w_apply;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_res    = '0;
                end else begin
                    w_ctl.pop = w_apply;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_res    = '0;
                end
            end
        endcase
    end

    // Cell chain: neighbors hand entries left or right
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_slot w_left;
        logic  w_left_keep;
        t_slot w_right;

        assign w_occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign w_left      = w_ctl.slot;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_slot[gi-1];
            assign w_left_keep = w_keep[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_slot[gi];
        end else begin : g_inner
            assign w_right = w_slot[gi+1];
        end

        skpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[gi]),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_slot      (w_slot[gi]),
            .o_keep      (w_keep[gi])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold the request fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_id     <= i_entity_id;
            r_weight <= i_weight;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_o_status <= w_status;
            r_o_id     <= w_res.id;
            r_o_key    <= w_res.key;
            r_o_occ    <= n_count;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_front_id  = r_o_id;
    assign o_front_key = r_o_key;
    assign o_occupancy = r_o_occ;

endmodule : speed_keyed_priority_queue_core

`default_nettype wire

// ===== rtl/core/skpq_div.sv =====
// ----------------------------------------------------------------------------
// skpq_div: iterative divider for the key quotient
// Restoring division of the key numerator by the speed, one quotient bit per
// cycle. A zero speed divides as one.
// ----------------------------------------------------------------------------
`default_nettype none

module skpq_div
    import skpq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SPEED_W-1:0] i_speed,
    output logic                    o_busy,
    output logic [QUO_W-1:0]        o_quo
);

    logic                r_busy;
    logic [STEP_W-1:0]   r_cnt;
    logic [QUO_W-1:0]    r_quo;
    logic [SPEED_W-1:0]  r_rem;
    logic [SPEED_W-1:0]  r_div;

    logic [SPEED_W:0]    w_sh;
    logic [SPEED_W:0]    w_diff;
    logic                w_ge;
    logic [QUO_W-1:0]    n_quo;
    logic [SPEED_W-1:0]  n_rem;

    // Shift in the next numerator bit and try the subtract
    always_comb begin
        w_sh   = {r_rem, r_quo[QUO_W-1]};
        w_diff = w_sh - {1'b0, r_div};
        w_ge   = (w_sh >= {1'b0, r_div});
        n_rem  = w_ge ? w_diff[SPEED_W-1:0] : w_sh[SPEED_W-1:0];
        n_quo  = QUO_W'({r_quo, w_ge});
    end

    // Control: count the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QUO_W'(KEY_NUMERATOR);
            r_rem <= '0;
            r_div <= (i_speed == '0) ? SPEED_W'(1) : i_speed;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule : skpq_div

`default_nettype wire

// ===== rtl/core/skpq_cell.sv =====
// ----------------------------------------------------------------------------
// skpq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes the new entry or takes
// its left neighbor's; on pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module skpq_cell
    import skpq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occ,
    input  wire t_slot     i_left,
    input  wire logic      i_left_keep,
    input  wire t_slot     i_right,
    output t_slot          o_slot,
    output logic           o_keep
);

    t_slot r_slot;
    t_slot n_slot;
    logic  w_keep;

    // Keep the stored entry when it sorts at or before the new key
    assign w_keep = i_occ && (r_slot.key <= i_ctl.slot.key);

    // Select the next entry
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            if (w_keep) begin
                n_slot = r_slot;
            end else if (i_left_keep) begin
                n_slot = i_ctl.slot;
            end else begin
                n_slot = i_left;
            end
        end else if (i_ctl.pop) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;
    assign o_keep = w_keep;

endmodule : skpq_cell

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for speed_keyed_priority_queue_core
// Drives insert, pop and peek requests through the valid/stall request port
// and checks every result against a sorted-queue predictor kept in a small
// scoreboard class. A directed sequence covers empty and full queues, key
// extremes, zero speed, equal keys and opcode three. Random bursts then swing
// the queue between full and empty under three idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
    import skpq_pkg::*;

    // Opcode three decodes like a peek
    localparam logic [OPC_W-1:0] OP_PEEK_ALIAS = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 24;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   front_id;
        logic [KEY_W-1:0]  front_key;
        logic [CNT_W-1:0]  occupancy;
    } t_front;

    // Bias of a random burst: mostly inserts, mostly takes, or even
    typedef enum int {
        MIX_FILL  = 0,
        MIX_DRAIN = 1,
        MIX_EVEN  = 2
    } t_mix;

    // Sorted queue predictor and checker of returned fronts
    class queue_scoreboard;
        logic [ID_W-1:0]  slot_id  [CAPACITY];
        logic [KEY_W-1:0] slot_key [CAPACITY];
        int unsigned      count;
        t_front           pending_fronts [$];
        int unsigned      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return pending_fronts.size();
        endfunction

        // Update the queue for one accepted request and store its front
        function void apply_request(logic [OPC_W-1:0] op, logic [ID_W-1:0] id,
                                    logic [SPEED_W-1:0] speed,
                                    logic [WEIGHT_W-1:0] weight);
            t_front           r;
            int unsigned      divisor;
            int unsigned      pos;
            int unsigned      i;
            logic [KEY_W-1:0] key;
            divisor = (speed == '0) ? 1 : speed;
            key = KEY_W'(KEY_NUMERATOR / divisor + weight);
            if (op == OP_INSERT) begin
                r.front_id  = id;
                r.front_key = key;
                if (count >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    // place behind every entry with an equal or smaller key
                    pos = 0;
                    while (pos < count && slot_key[pos] <= key)
                        pos++;
                    for (i = count; i > pos; i--) begin
                        slot_id[i]  = slot_id[i-1];
                        slot_key[i] = slot_key[i-1];
                    end
                    slot_id[pos]  = id;
                    slot_key[pos] = key;
                    count++;
                    r.status = STAT_OK;
                end
            end else if (count == 0) begin
                r.status    = STAT_EMPTY;
                r.front_id  = '0;
                r.front_key = '0;
            end else begin
                r.status    = STAT_OK;
                r.front_id  = slot_id[0];
                r.front_key = slot_key[0];
                // pop shifts the queue up; peek and opcode three leave it
                if (op == OP_POP) begin
                    for (i = 0; i + 1 < count; i++) begin
                        slot_id[i]  = slot_id[i+1];
                        slot_key[i] = slot_key[i+1];
                    end
                    count--;
                end
            end
            r.occupancy = CNT_W'(count);
            pending_fronts.push_back(r);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", field, got, want);
            errors++;
        endtask

        // Compare one accepted result with the oldest stored front
        task check_front(logic [STAT_W-1:0] status, logic [ID_W-1:0] id,
                         logic [KEY_W-1:0] key, logic [CNT_W-1:0] occupancy);
            t_front want;
            if (pending_fronts.size() == 0) begin
                report_mismatch("result with no request pending", id, 0);
            end else begin
                want = pending_fronts.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (id !== want.front_id)
                    report_mismatch("front_id", id, want.front_id);
                if (key !== want.front_key)
                    report_mismatch("front_key", key, want.front_key);
                if (occupancy !== want.occupancy)
                    report_mismatch("occupancy", occupancy, want.occupancy);
            end
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic [OPC_W-1:0]    i_opcode    = '0;
    logic [ID_W-1:0]     i_entity_id = '0;
    logic [SPEED_W-1:0]  i_speed     = '0;
    logic [WEIGHT_W-1:0] i_weight    = '0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [ID_W-1:0]     o_front_id;
    logic [KEY_W-1:0]    o_front_key;
    logic [CNT_W-1:0]    o_occupancy;

    queue_scoreboard sb;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     quiet_cycles   = 0;

    speed_keyed_priority_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_entity_id (i_entity_id),
        .i_speed     (i_speed),
        .i_weight    (i_weight),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_front_id  (o_front_id),
        .o_front_key (o_front_key),
        .o_occupancy (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result port at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check results, record requests, and watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_front(o_status, o_front_id, o_front_key, o_occupancy);
        if (i_rst_n && i_valid && !o_stall)
            sb.apply_request(i_opcode, i_entity_id, i_speed, i_weight);
        if (i_rst_n && ((o_valid && !i_stall) || (i_valid && !o_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle at random, then present one request and hold it until accepted
    task automatic send_request(input logic [OPC_W-1:0] op,
                                input logic [ID_W-1:0] id,
                                input logic [SPEED_W-1:0] speed,
                                input logic [WEIGHT_W-1:0] weight);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_entity_id <= id;
        i_speed     <= speed;
        i_weight    <= weight;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold off new requests until every result has come back
    task automatic drain_queue();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // One random request whose opcode leans toward the given mix
    task automatic send_random_request(input t_mix mix);
        int unsigned         insert_pct;
        int unsigned         pick;
        logic [OPC_W-1:0]    op;
        logic [SPEED_W-1:0]  speed;
        logic [WEIGHT_W-1:0] weight;
        case (mix)
            MIX_FILL:  insert_pct = 85;
            MIX_DRAIN: insert_pct = 20;
            default:   insert_pct = 50;
        endcase
        if ($urandom_range(99) < insert_pct) begin
            op = OP_INSERT;
        end else begin
            pick = $urandom_range(9);
            op = (pick < 6) ? OP_POP : (pick < 9) ? OP_PEEK : OP_PEEK_ALIAS;
        end
        // narrow buckets make equal keys common
        case ($urandom_range(2))
            0:       speed = SPEED_W'($urandom_range(255));
            1:       speed = SPEED_W'($urandom_range(3));
            default: speed = SPEED_W'($urandom_range(255, 248));
        endcase
        case ($urandom_range(3))
            0:       weight = WEIGHT_W'($urandom);
            1:       weight = WEIGHT_W'($urandom_range(15));
            2:       weight = WEIGHT_W'(16'hFFFF - $urandom_range(15));
            default: weight = '0;
        endcase
        send_request(op, ID_W'($urandom), speed, weight);
    endtask

    // Random bursts, each with its own mix, with an occasional full drain
    task automatic run_phase(input int unsigned items);
        int unsigned sent;
        int unsigned burst;
        t_mix        mix;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(24, 4);
            if (burst > items - sent)
                burst = items - sent;
            mix   = t_mix'($urandom_range(2));
            repeat (burst) begin
                send_random_request(mix);
                sent++;
                if ($urandom_range(39) == 0)
                    drain_queue();
            end
        end
    endtask

    initial begin
        int k;
        sb = new();
        send_idle_pct  = 16;
        recv_stall_pct = 74;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // take from an empty queue with every non-insert opcode
        send_request(OP_PEEK, '1, '1, '1);
        send_request(OP_POP, '0, '0, '0);
        send_request(OP_PEEK_ALIAS, ID_W'($urandom), '0, '0);

        // zero speed, largest and smallest keys, equal keys in arrival order
        send_request(OP_INSERT, 10'd0, 8'd0, 16'd0);
        send_request(OP_INSERT, 10'd1023, 8'd255, 16'hFFFF);
        send_request(OP_INSERT, 10'd1, 8'd1, 16'hFFFF);
        send_request(OP_INSERT, 10'd2, 8'd1, 16'd0);
        send_request(OP_INSERT, 10'd3, 8'd2, 16'd500);
        send_request(OP_INSERT, 10'd4, 8'd255, 16'd0);

        // fill to capacity, then insert into the full queue
        for (k = 0; k < 10; k++)
            send_request(OP_INSERT, ID_W'(16 + k), SPEED_W'(1 << (k % 8)),
                         WEIGHT_W'(1 << k));
        send_request(OP_INSERT, 10'h2AA, 8'd0, 16'hFFFF);
        send_request(OP_PEEK, '0, '0, '0);
        send_request(OP_PEEK_ALIAS, '1, '1, '1);
        send_request(OP_POP, ID_W'($urandom), SPEED_W'($urandom), '0);
        send_request(OP_POP, '0, '0, WEIGHT_W'($urandom));
        drain_queue();

        run_phase(134);
        drain_queue();
        send_idle_pct  = 74;
        recv_stall_pct = 16;
        run_phase(134);
        drain_queue();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(134);
        drain_queue();

        // catch any stray result after the last one expected
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/skpq_pkg.sv
rtl/core/skpq_div.sv
rtl/core/skpq_cell.sv
rtl/core/speed_keyed_priority_queue_core.sv
tb/sv/tb_top.sv
